FILE: design/descriptor_pipe_fifo_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Descriptor pipe engine assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_PIPE_FIFO_ENGINE_UNIT_MACROS_SVH
`define DESCRIPTOR_PIPE_FIFO_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define DPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Sizes, codes and helper functions of the descriptor pipe engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpf_pkg;

  localparam int DESCRIPTORS   = 32;
  localparam int PIPES         = 4;
  localparam int PIPE_DEPTH    = 4096;

  localparam int FD_W          = $clog2(DESCRIPTORS);
  localparam int PIPE_W        = (PIPES > 1) ? $clog2(PIPES) : 1;
  localparam int POS_W         = $clog2(PIPE_DEPTH);
  localparam int CNT_W         = $clog2(PIPE_DEPTH + 1);
  localparam int ADDR_W        = PIPE_W + POS_W;
  localparam int REF_W         = 6;
  localparam int FIRST_USER_FD = 3;

  localparam logic [REF_W-1:0] REF_MAX = 6'd63;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_FREE    = 3'd0;
  localparam kind_t KIND_STDIN   = 3'd1;
  localparam kind_t KIND_STDOUT  = 3'd2;
  localparam kind_t KIND_STDERR  = 3'd3;
  localparam kind_t KIND_PIPE_RD = 3'd5;
  localparam kind_t KIND_PIPE_WR = 3'd6;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_DUP    = 3'd3;
  localparam logic [2:0] OP_CLOSE  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_STD     = 3'd4;

  // lowest set bit, descriptor table
  function automatic logic [FD_W-1:0] first_fd(input logic [DESCRIPTORS-1:0] v);
    logic [FD_W-1:0] idx;
    idx = '0;
    for (int i = DESCRIPTORS - 1; i >= 0; i--) begin
      if (v[i]) idx = FD_W'(i);
    end
    return idx;
  endfunction

  // lowest set bit, pipe table
  function automatic logic [PIPE_W-1:0] first_pipe(input logic [PIPES-1:0] v);
    logic [PIPE_W-1:0] idx;
    idx = '0;
    for (int i = PIPES - 1; i >= 0; i--) begin
      if (v[i]) idx = PIPE_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: design/dpf_ring.sv
// ----------------------------------------------------------------------------
// dpf_ring
// Byte store shared by all pipe rings: one write, one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpf_ring (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [dpf_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [dpf_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                 rd_data
);
  import dpf_pkg::*;

  localparam int WORDS = 2 ** ADDR_W;

  logic [7:0] mem [WORDS];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/descriptor_pipe_fifo_engine_unit.sv
// ----------------------------------------------------------------------------
// descriptor_pipe_fifo_engine_unit
// Descriptor table over byte ring pipes with reference counting.
// ----------------------------------------------------------------------------
// One word in, one result word out. The block takes one word at a time: a
// create, write or close passes S_DEC and S_RESP from accept to the next
// accept, a read that finds a byte also S_RD (the ring store has a registered
// read port), and a duplicate onto another entry also S_REL and S_COPY (the
// shared descriptor update unit first releases the target, then copies the
// source onto it). S_RESP loads the result word into the output register. The
// result register lets the next word be accepted while a result still waits
// for out_ready. The byte store needs no clearing after reset.
`timescale 1ns / 1ps

module descriptor_pipe_fifo_engine_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [5:0] in_fd,
  input  logic [5:0] in_target_fd,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_read_byte,
  output logic [4:0] out_first_fd,
  output logic [4:0] out_second_fd
);
  import dpf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_REL  = 6'b000100,
    S_COPY = 6'b001000,
    S_RD   = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0] op_r;
  logic [5:0] fd_r, tfd_r;
  logic [7:0] byte_r;

  kind_t            desc_kind_r [DESCRIPTORS];
  kind_t            desc_kind_nxt [DESCRIPTORS];
  logic [PIPE_W-1:0] desc_pipe_r [DESCRIPTORS];
  logic [PIPE_W-1:0] desc_pipe_nxt [DESCRIPTORS];

  logic [PIPES-1:0] in_use_r, in_use_nxt;
  logic [REF_W-1:0] rd_refs_r [PIPES];
  logic [REF_W-1:0] rd_refs_nxt [PIPES];
  logic [REF_W-1:0] wr_refs_r [PIPES];
  logic [REF_W-1:0] wr_refs_nxt [PIPES];
  logic [POS_W-1:0] head_r [PIPES];
  logic [POS_W-1:0] head_nxt [PIPES];
  logic [POS_W-1:0] tail_r [PIPES];
  logic [POS_W-1:0] tail_nxt [PIPES];
  logic [CNT_W-1:0] fill_r [PIPES];
  logic [CNT_W-1:0] fill_nxt [PIPES];

  kind_t             src_kind_r, src_kind_nxt;
  logic [PIPE_W-1:0] src_pipe_r, src_pipe_nxt;

  logic [2:0] res_status_r, res_status_nxt;
  logic [7:0] res_byte_r, res_byte_nxt;
  logic [4:0] res_f1_r, res_f1_nxt;
  logic [4:0] res_f2_r, res_f2_nxt;

  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [7:0] out_byte_r;
  logic [4:0] out_f1_r, out_f2_r;

  // ring store port
  logic              mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
  logic [7:0]        mem_rd_data;

  // decode helpers
  logic [FD_W-1:0]        fdi, tfdi, rel_d, alloc_r, alloc_w, tgt;
  logic                   fd_ok, tfd_ok, rel_en;
  kind_t                  k;
  logic [PIPE_W-1:0]      p, rp, np;
  logic [DESCRIPTORS-1:0] free_vec, free_vec2;
  logic                   load_out;

  assign fdi    = fd_r[FD_W-1:0];
  assign tfdi   = tfd_r[FD_W-1:0];
  assign fd_ok  = (int'(fd_r) < DESCRIPTORS) && (desc_kind_r[fdi] != KIND_FREE);
  assign tfd_ok = int'(tfd_r) < DESCRIPTORS;
  assign k      = desc_kind_r[fdi];
  assign p      = desc_pipe_r[fdi];

  always_comb begin
    for (int i = 0; i < DESCRIPTORS; i++) begin
      free_vec[i] = (desc_kind_r[i] == KIND_FREE) && (i >= FIRST_USER_FD);
    end
  end

  assign alloc_r   = first_fd(free_vec);
  assign free_vec2 = free_vec & ~(DESCRIPTORS'(1) << alloc_r);
  assign alloc_w   = first_fd(free_vec2);
  assign np        = first_pipe(~in_use_r);
  assign load_out  = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    desc_kind_nxt  = desc_kind_r;
    desc_pipe_nxt  = desc_pipe_r;
    in_use_nxt     = in_use_r;
    rd_refs_nxt    = rd_refs_r;
    wr_refs_nxt    = wr_refs_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    src_kind_nxt   = src_kind_r;
    src_pipe_nxt   = src_pipe_r;
    res_status_nxt = res_status_r;
    res_byte_nxt   = res_byte_r;
    res_f1_nxt     = res_f1_r;
    res_f2_nxt     = res_f2_r;
    mem_wr_en      = 1'b0;
    mem_rd_en      = 1'b0;
    mem_wr_addr    = {p, tail_r[p]};
    mem_rd_addr    = {p, head_r[p]};
    rel_en         = 1'b0;
    rel_d          = fdi;
    rp             = '0;
    tgt            = tfdi;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        res_status_nxt = ST_INVALID;
        res_byte_nxt   = '0;
        res_f1_nxt     = '0;
        res_f2_nxt     = '0;
        state_nxt      = S_RESP;
        case (op_r)
          OP_CREATE: begin
            if (!(&in_use_r)) begin
              rd_refs_nxt[np] = (|free_vec) ? '0 : REF_W'(1);
              wr_refs_nxt[np] = REF_W'(1);
              head_nxt[np]    = '0;
              tail_nxt[np]    = '0;
              fill_nxt[np]    = '0;
              if ((|free_vec) && (|free_vec2)) begin
                rd_refs_nxt[np]        = REF_W'(1);
                in_use_nxt[np]         = 1'b1;
                desc_kind_nxt[alloc_r] = KIND_PIPE_RD;
                desc_pipe_nxt[alloc_r] = np;
                desc_kind_nxt[alloc_w] = KIND_PIPE_WR;
                desc_pipe_nxt[alloc_w] = np;
                res_status_nxt         = ST_OK;
                res_f1_nxt             = 5'(alloc_r);
                res_f2_nxt             = 5'(alloc_w);
              end
            end
          end
          OP_WRITE: begin
            if (fd_ok) begin
              if (k == KIND_STDOUT || k == KIND_STDERR) begin
                res_status_nxt = ST_STD;
              end else if (k == KIND_PIPE_WR && in_use_r[p]) begin
                if (int'(fill_r[p]) >= PIPE_DEPTH) begin
                  res_status_nxt = ST_FULL;
                end else begin
                  mem_wr_en      = 1'b1;
                  tail_nxt[p]    = (int'(tail_r[p]) == PIPE_DEPTH - 1) ? '0
                                   : tail_r[p] + 1'b1;
                  fill_nxt[p]    = fill_r[p] + 1'b1;
                  res_status_nxt = ST_OK;
                end
              end
            end
          end
          OP_READ: begin
            if (fd_ok) begin
              if (k == KIND_STDIN) begin
                res_status_nxt = ST_STD;
              end else if (k == KIND_PIPE_RD && in_use_r[p]) begin
                if (fill_r[p] == '0) begin
                  res_status_nxt = ST_EMPTY;
                end else begin
                  mem_rd_en      = 1'b1;
                  head_nxt[p]    = (int'(head_r[p]) == PIPE_DEPTH - 1) ? '0
                                   : head_r[p] + 1'b1;
                  fill_nxt[p]    = fill_r[p] - 1'b1;
                  res_status_nxt = ST_OK;
                  state_nxt      = S_RD;
                end
              end
            end
          end
          OP_DUP: begin
            if (fd_ok && tfd_ok) begin
              res_status_nxt = ST_OK;
              res_f1_nxt     = 5'(tfdi);
              src_kind_nxt   = k;
              src_pipe_nxt   = p;
              if (fd_r != tfd_r) state_nxt = S_REL;
            end
          end
          OP_CLOSE: begin
            if (fd_ok) begin
              rel_en         = 1'b1;
              rel_d          = fdi;
              res_status_nxt = ST_OK;
            end
          end
          default: ;
        endcase
      end
      S_REL: begin
        rel_en    = 1'b1;
        rel_d     = tfdi;
        state_nxt = S_COPY;
      end
      S_COPY: begin
        desc_kind_nxt[tgt] = src_kind_r;
        desc_pipe_nxt[tgt] = src_pipe_r;
        if (src_kind_r == KIND_PIPE_RD && rd_refs_r[src_pipe_r] < REF_MAX)
          rd_refs_nxt[src_pipe_r] = rd_refs_r[src_pipe_r] + 1'b1;
        else if (src_kind_r == KIND_PIPE_WR && wr_refs_r[src_pipe_r] < REF_MAX)
          wr_refs_nxt[src_pipe_r] = wr_refs_r[src_pipe_r] + 1'b1;
        state_nxt = S_RESP;
      end
      S_RD: begin
        res_byte_nxt = mem_rd_data;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // shared release path: drop the pipe reference, then free the entry
    if (rel_en && int'(rel_d) >= FIRST_USER_FD && desc_kind_r[rel_d] != KIND_FREE) begin
      rp = desc_pipe_r[rel_d];
      if (in_use_r[rp]) begin
        if (desc_kind_r[rel_d] == KIND_PIPE_RD && rd_refs_r[rp] != '0)
          rd_refs_nxt[rp] = rd_refs_r[rp] - 1'b1;
        else if (desc_kind_r[rel_d] == KIND_PIPE_WR && wr_refs_r[rp] != '0)
          wr_refs_nxt[rp] = wr_refs_r[rp] - 1'b1;
        if (rd_refs_nxt[rp] == '0 && wr_refs_nxt[rp] == '0) begin
          in_use_nxt[rp] = 1'b0;
          head_nxt[rp]   = '0;
          tail_nxt[rp]   = '0;
          fill_nxt[rp]   = '0;
        end
      end
      desc_kind_nxt[rel_d] = KIND_FREE;
      desc_pipe_nxt[rel_d] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      in_use_r    <= '0;
      for (int i = 0; i < DESCRIPTORS; i++) begin
        desc_kind_r[i] <= KIND_FREE;
        desc_pipe_r[i] <= '0;
      end
      desc_kind_r[0] <= KIND_STDIN;
      desc_kind_r[1] <= KIND_STDOUT;
      desc_kind_r[2] <= KIND_STDERR;
      for (int i = 0; i < PIPES; i++) begin
        rd_refs_r[i] <= '0;
        wr_refs_r[i] <= '0;
        head_r[i]    <= '0;
        tail_r[i]    <= '0;
        fill_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      desc_kind_r <= desc_kind_nxt;
      desc_pipe_r <= desc_pipe_nxt;
      in_use_r    <= in_use_nxt;
      rd_refs_r   <= rd_refs_nxt;
      wr_refs_r   <= wr_refs_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      if (load_out)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_opcode;
      fd_r   <= in_fd;
      tfd_r  <= in_target_fd;
      byte_r <= in_data_byte;
    end
    src_kind_r   <= src_kind_nxt;
    src_pipe_r   <= src_pipe_nxt;
    res_status_r <= res_status_nxt;
    res_byte_r   <= res_byte_nxt;
    res_f1_r     <= res_f1_nxt;
    res_f2_r     <= res_f2_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_byte_r   <= res_byte_r;
      out_f1_r     <= res_f1_r;
      out_f2_r     <= res_f2_r;
    end
  end

  dpf_ring u_ring (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (byte_r),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_byte = out_byte_r;
  assign out_first_fd  = out_f1_r;
  assign out_second_fd = out_f2_r;

endmodule

FILE: design/dpf_checker.sv
// ----------------------------------------------------------------------------
// dpf_checker
// Port-level checks of the descriptor pipe engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "descriptor_pipe_fifo_engine_unit_macros.svh"

module dpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [7:0] out_read_byte,
  input logic [4:0] out_second_fd
);
  import dpf_pkg::*;

  // a stalled result word holds
  `DPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status), "result word dropped or changed while stalled")

  // busy after taking a word
  `DPF_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "second word taken while busy")

  // only a successful create returns a write descriptor
  `DPF_ASSERT_NOW(a_f2_zero, out_valid && out_status != ST_OK, out_second_fd == '0, "write descriptor on failed word")

  // failed words carry no byte
  `DPF_ASSERT_NOW(a_byte_zero, out_valid && out_status != ST_OK, out_read_byte == '0, "read byte on failed word")

  // status codes stay in range
  `DPF_ASSERT_NOW(a_status, out_valid, out_status == ST_OK || out_status == ST_INVALID || out_status == ST_EMPTY || out_status == ST_FULL || out_status == ST_STD, "bad status code")

endmodule

bind descriptor_pipe_fifo_engine_unit dpf_checker u_dpf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_read_byte (out_read_byte),
  .out_second_fd (out_second_fd)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Descriptor pipe engine testbench
// Runs directed and random command words through the engine and checks each
// result word against an in-bench model of the descriptor table and the rings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dpf_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [2:0] status;
    logic [7:0] rbyte;
    logic [4:0] fd_a;
    logic [4:0] fd_b;
  } result_t;

  typedef struct {
    logic [2:0] op;
    logic [5:0] fd;
    logic [5:0] tfd;
    logic [7:0] data;
    bit         drain_first;
    bit         rush;
    result_t    want;
  } cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_opcode = '0;
  logic [5:0] in_fd = '0;
  logic [5:0] in_target_fd = '0;
  logic [7:0] in_data_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_read_byte;
  logic [4:0] out_first_fd;
  logic [4:0] out_second_fd;

  descriptor_pipe_fifo_engine_unit uut (.*);

  always #1 clk = ~clk;

  // model state
  kind_t            kind_tab [DESCRIPTORS];
  logic [PIPE_W-1:0] pipe_tab [DESCRIPTORS];
  bit               busy_pipe [PIPES];
  int               rd_refs [PIPES];
  int               wr_refs [PIPES];
  int               rd_ptr [PIPES];
  int               wr_ptr [PIPES];
  int               level [PIPES];
  logic [7:0]       ring [PIPES*PIPE_DEPTH];

  cmd_t    cmd_q [$];
  result_t result_q [$];
  cmd_t    cur;
  int      errors = 0;
  int      cycles = 0;
  int      gap = 0;
  int      stall = 0;
  bit      busy = 0;
  bit      took = 0;
  bit      rush = 0;
  bit      next_pause = 0;
  bit      next_rush = 0;

  function automatic void drop_ref(int d);
    int p;
    p = pipe_tab[d];
    if (!busy_pipe[p]) return;
    if (kind_tab[d] == KIND_PIPE_RD && rd_refs[p] > 0) rd_refs[p]--;
    else if (kind_tab[d] == KIND_PIPE_WR && wr_refs[p] > 0) wr_refs[p]--;
    if (rd_refs[p] == 0 && wr_refs[p] == 0) begin
      busy_pipe[p] = 0;
      rd_ptr[p] = 0;
      wr_ptr[p] = 0;
      level[p] = 0;
    end
  endfunction

  function automatic void free_fd(int d);
    if (d >= DESCRIPTORS || kind_tab[d] == KIND_FREE || d < FIRST_USER_FD) return;
    drop_ref(d);
    kind_tab[d] = KIND_FREE;
    pipe_tab[d] = '0;
  endfunction

  function automatic int grab_fd(kind_t k, int p);
    for (int d = FIRST_USER_FD; d < DESCRIPTORS; d++) begin
      if (kind_tab[d] == KIND_FREE) begin
        kind_tab[d] = k;
        pipe_tab[d] = PIPE_W'(p);
        return d;
      end
    end
    return DESCRIPTORS;
  endfunction

  function automatic result_t engine_step(logic [2:0] op, logic [5:0] fd, logic [5:0] tfd,
                                          logic [7:0] data);
    result_t r;
    bit      fd_ok;
    int      p;
    int      rd;
    int      wr;
    kind_t   k;
    r = '{ST_INVALID, 8'd0, 5'd0, 5'd0};
    fd_ok = fd < DESCRIPTORS && kind_tab[fd] != KIND_FREE;
    if (fd_ok) begin
      k = kind_tab[fd];
      p = pipe_tab[fd];
    end
    if (op == OP_CREATE) begin
      p = PIPES;
      for (int i = PIPES - 1; i >= 0; i--) if (!busy_pipe[i]) p = i;
      if (p < PIPES) begin
        busy_pipe[p] = 1;
        rd_refs[p] = 1;
        wr_refs[p] = 1;
        rd_ptr[p] = 0;
        wr_ptr[p] = 0;
        level[p] = 0;
        rd = grab_fd(KIND_PIPE_RD, p);
        wr = grab_fd(KIND_PIPE_WR, p);
        if (rd >= DESCRIPTORS || wr >= DESCRIPTORS) begin
          // undo a half-finished create
          if (rd < DESCRIPTORS) free_fd(rd);
          busy_pipe[p] = 0;
        end else begin
          r.status = ST_OK;
          r.fd_a = 5'(rd);
          r.fd_b = 5'(wr);
        end
      end
    end else if (op == OP_WRITE && fd_ok) begin
      if (k == KIND_STDOUT || k == KIND_STDERR) r.status = ST_STD;
      else if (k == KIND_PIPE_WR && busy_pipe[p]) begin
        if (level[p] >= PIPE_DEPTH) r.status = ST_FULL;
        else begin
          ring[p*PIPE_DEPTH + wr_ptr[p]] = data;
          wr_ptr[p] = (wr_ptr[p] + 1) % PIPE_DEPTH;
          level[p]++;
          r.status = ST_OK;
        end
      end
    end else if (op == OP_READ && fd_ok) begin
      if (k == KIND_STDIN) r.status = ST_STD;
      else if (k == KIND_PIPE_RD && busy_pipe[p]) begin
        if (level[p] == 0) r.status = ST_EMPTY;
        else begin
          r.rbyte = ring[p*PIPE_DEPTH + rd_ptr[p]];
          rd_ptr[p] = (rd_ptr[p] + 1) % PIPE_DEPTH;
          level[p]--;
          r.status = ST_OK;
        end
      end
    end else if (op == OP_DUP && fd_ok && tfd < DESCRIPTORS) begin
      r.status = ST_OK;
      r.fd_a = tfd[4:0];
      if (fd != tfd) begin
        free_fd(tfd);
        kind_tab[tfd] = kind_tab[fd];
        pipe_tab[tfd] = pipe_tab[fd];
        p = pipe_tab[tfd];
        if (kind_tab[tfd] == KIND_PIPE_RD && rd_refs[p] < REF_MAX) rd_refs[p]++;
        else if (kind_tab[tfd] == KIND_PIPE_WR && wr_refs[p] < REF_MAX) wr_refs[p]++;
      end
    end else if (op == OP_CLOSE && fd_ok) begin
      free_fd(fd);
      r.status = ST_OK;
    end
    return r;
  endfunction

  function automatic result_t add(logic [2:0] op, logic [5:0] fd, logic [5:0] tfd,
                                  logic [7:0] data);
    cmd_t c;
    c.op = op;
    c.fd = fd;
    c.tfd = tfd;
    c.data = data;
    c.drain_first = next_pause;
    c.rush = next_rush;
    c.want = engine_step(op, fd, tfd, data);
    next_pause = 0;
    cmd_q.push_back(c);
    return c.want;
  endfunction

  // random descriptor of the given kind, or any value from 0 to 63 when none exists
  function automatic logic [5:0] pick_fd(kind_t k);
    int s;
    s = $urandom_range(0, DESCRIPTORS - 1);
    for (int i = 0; i < DESCRIPTORS; i++) begin
      if (kind_tab[(s + i) % DESCRIPTORS] == k) return 6'((s + i) % DESCRIPTORS);
    end
    return 6'($urandom_range(0, 63));
  endfunction

  initial begin
    result_t r;
    int      sel;
    for (int d = 0; d < DESCRIPTORS; d++) begin
      kind_tab[d] = KIND_FREE;
      pipe_tab[d] = '0;
    end
    kind_tab[0] = KIND_STDIN;
    kind_tab[1] = KIND_STDOUT;
    kind_tab[2] = KIND_STDERR;
    for (int p = 0; p < PIPES; p++) begin
      busy_pipe[p] = 0;
      rd_refs[p] = 0;
      wr_refs[p] = 0;
      rd_ptr[p] = 0;
      wr_ptr[p] = 0;
      level[p] = 0;
    end

    // directed
    void'(add(OP_CREATE, 6'd0, 6'd0, 8'd0));
    void'(add(OP_WRITE, 6'd4, 6'd0, 8'hff));
    void'(add(OP_WRITE, 6'd4, 6'd63, 8'h00));
    void'(add(OP_READ, 6'd3, 6'd0, 8'd0));
    void'(add(OP_READ, 6'd3, 6'd0, 8'd0));
    void'(add(OP_READ, 6'd3, 6'd0, 8'd0));
    void'(add(OP_WRITE, 6'd1, 6'd0, 8'h5a));
    void'(add(OP_WRITE, 6'd2, 6'd0, 8'ha5));
    void'(add(OP_READ, 6'd0, 6'd0, 8'd0));
    void'(add(OP_WRITE, 6'd0, 6'd0, 8'd1));
    void'(add(OP_READ, 6'd1, 6'd0, 8'd0));
    void'(add(OP_WRITE, 6'd3, 6'd0, 8'd2));
    void'(add(3'd5, 6'd3, 6'd4, 8'd0));
    void'(add(3'd6, 6'd4, 6'd3, 8'd0));
    void'(add(3'd7, 6'd63, 6'd63, 8'hff));
    void'(add(OP_WRITE, 6'd63, 6'd0, 8'd3));
    void'(add(OP_CLOSE, 6'd20, 6'd0, 8'd0));
    void'(add(OP_DUP, 6'd4, 6'd4, 8'd0));
    void'(add(OP_DUP, 6'd3, 6'd63, 8'd0));
    void'(add(OP_DUP, 6'd3, 6'd10, 8'd0));
    void'(add(OP_CLOSE, 6'd2, 6'd0, 8'd0));
    void'(add(OP_CLOSE, 6'd10, 6'd0, 8'd0));
    for (int i = 0; i < 4; i++) void'(add(OP_CREATE, 6'd0, 6'd0, 8'd0));

    // reference counts saturate when standard entries are dup targets
    next_pause = 1;
    for (int i = 0; i < 70; i++) void'(add(OP_DUP, 6'd4, 6'd0, 8'(i)));
    for (int i = 0; i < 70; i++) void'(add(OP_DUP, 6'd3, 6'd1, 8'(i)));
    void'(add(OP_WRITE, 6'd0, 6'd0, 8'h77));
    void'(add(OP_READ, 6'd1, 6'd0, 8'd0));
    for (int d = 3; d < DESCRIPTORS; d++) void'(add(OP_CLOSE, 6'(d), 6'd0, 8'd0));

    // descriptor table exhausted: create must back out its read end
    r = add(OP_CREATE, 6'd0, 6'd0, 8'd0);
    for (int d = r.fd_b + 1; d < DESCRIPTORS - 1; d++)
      void'(add(OP_DUP, 6'(r.fd_b), 6'(d), 8'd0));
    void'(add(OP_CREATE, 6'd0, 6'd0, 8'd0));
    void'(add(OP_CREATE, 6'd0, 6'd0, 8'd0));
    for (int d = 3; d < DESCRIPTORS; d++) void'(add(OP_CLOSE, 6'(d), 6'd0, 8'd0));

    // random traffic, mostly well-formed
    for (int i = 0; i < 1050; i++) begin
      if (i % 300 == 150) next_pause = 1;
      next_rush = (i >= 600 && i < 700);
      sel = $urandom_range(0, 99);
      if (sel < 6)
        void'(add(3'($urandom_range(0, 7)), 6'($urandom), 6'($urandom), 8'($urandom)));
      else if (sel < 40)
        void'(add(OP_WRITE, pick_fd(KIND_PIPE_WR), 6'($urandom), 8'($urandom)));
      else if (sel < 75)
        void'(add(OP_READ, pick_fd(KIND_PIPE_RD), 6'($urandom), 8'($urandom)));
      else if (sel < 84)
        void'(add(OP_CREATE, 6'($urandom), 6'($urandom), 8'($urandom)));
      else if (sel < 91)
        void'(add(OP_DUP, pick_fd($urandom_range(0, 1) ? KIND_PIPE_RD : KIND_PIPE_WR),
                  $urandom_range(0, 9) == 0 ? 6'($urandom) : 6'($urandom_range(0, 31)),
                  8'($urandom)));
      else
        void'(add(OP_CLOSE, $urandom_range(0, 1) ? pick_fd(KIND_PIPE_RD)
                  : 6'($urandom_range(3, 31)), 6'($urandom), 8'($urandom)));
    end
    next_rush = 0;

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (cmd_q.size() == 0 && !busy && result_q.size() == 0);
    repeat (30) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // driver
  always @(negedge clk) begin
    bit nv;
    nv = in_valid;
    if (rst_n) begin
      if (busy && took) begin
        busy = 0;
        took = 0;
        nv = 0;
      end
      if (!busy) begin
        if (gap > 0) begin
          gap--;
        end else if (cmd_q.size() != 0 &&
                     !(cmd_q[0].drain_first && result_q.size() != 0)) begin
          cur = cmd_q.pop_front();
          rush = cur.rush;
          in_opcode <= cur.op;
          in_fd <= cur.fd;
          in_target_fd <= cur.tfd;
          in_data_byte <= cur.data;
          nv = 1;
          busy = 1;
          gap = rush ? 0 : $urandom_range(0, 19);
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
    in_valid <= nv;
  end

  // monitor
  always @(posedge clk) begin
    result_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) begin
        result_q.push_back(cur.want);
        took = 1;
      end
      if (out_valid && out_ready) begin
        stall = rush ? 0 : $urandom_range(0, 19);
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word, status %0d", out_status);
        end else begin
          w = result_q.pop_front();
          if (out_status !== w.status || out_read_byte !== w.rbyte ||
              out_first_fd !== w.fd_a || out_second_fd !== w.fd_b) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st %0d byte %h fd %0d/%0d, got st %0d byte %h fd %0d/%0d",
                       w.status, w.rbyte, w.fd_a, w.fd_b, out_status, out_read_byte,
                       out_first_fd, out_second_fd);
          end
        end
      end
    end
  end

endmodule
